/* src/aabb_pkg.sv */
`default_nettype none

package aabb_pkg;

    localparam int COORD_BITS = 32;
    localparam int COEFF_BITS = 16;
    localparam int COEFF_FRAC = 12;
    localparam int AXES = 3;
    localparam int COEFF_REG_BITS = AXES * COEFF_BITS;
    localparam int FULL_PROD_BITS = COORD_BITS + COEFF_BITS;
    localparam int PROD_BITS = FULL_PROD_BITS - COEFF_FRAC;
    localparam int SUM_BITS = PROD_BITS + 2;
    localparam int CFG_DATA_BITS = COEFF_REG_BITS;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_FROM_X_COEFFS = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FROM_Y_COEFFS = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FROM_Z_COEFFS = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TRANS_X = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TRANS_Y = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_TRANS_Z = 3'd5;

    localparam logic [COEFF_BITS-1:0] COEFF_ONE = COEFF_BITS'(1 << COEFF_FRAC);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [AXES-1:0][COORD_BITS-1:0] coord3_t;
    typedef logic [AXES-1:0][COEFF_BITS-1:0] coeff3_t;
    typedef logic [COEFF_REG_BITS-1:0] coeff_row_t;

    typedef struct packed {
        logic prod;
        logic res;
    } stage_en_t;

    function automatic coord_t sat_coord(input logic [SUM_BITS-1:0] sum);
        logic [SUM_BITS-COORD_BITS:0] top;
        coord_t result;
        top = sum[SUM_BITS-1:COORD_BITS-1];
        if ((top == '0) || (top == '1))
        begin
            result = sum[COORD_BITS-1:0];
        end
        else if (sum[SUM_BITS-1])
        begin
            result = {1'b1, {(COORD_BITS-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return result;
    endfunction

endpackage

`default_nettype wire

/* src/aabb_in_if.sv */
`default_nettype none

interface aabb_in_if;
    logic valid;
    logic ready;
    logic [aabb_pkg::COORD_BITS-1:0] in_lo_x;
    logic [aabb_pkg::COORD_BITS-1:0] in_lo_y;
    logic [aabb_pkg::COORD_BITS-1:0] in_lo_z;
    logic [aabb_pkg::COORD_BITS-1:0] in_hi_x;
    logic [aabb_pkg::COORD_BITS-1:0] in_hi_y;
    logic [aabb_pkg::COORD_BITS-1:0] in_hi_z;

    modport source (
        output valid, in_lo_x, in_lo_y, in_lo_z, in_hi_x, in_hi_y, in_hi_z,
        input ready
    );
    modport sink (
        input valid, in_lo_x, in_lo_y, in_lo_z, in_hi_x, in_hi_y, in_hi_z,
        output ready
    );
endinterface

`default_nettype wire

/* src/aabb_out_if.sv */
`default_nettype none

interface aabb_out_if;
    logic valid;
    logic ready;
    logic [aabb_pkg::COORD_BITS-1:0] out_lo_x;
    logic [aabb_pkg::COORD_BITS-1:0] out_lo_y;
    logic [aabb_pkg::COORD_BITS-1:0] out_lo_z;
    logic [aabb_pkg::COORD_BITS-1:0] out_hi_x;
    logic [aabb_pkg::COORD_BITS-1:0] out_hi_y;
    logic [aabb_pkg::COORD_BITS-1:0] out_hi_z;

    modport source (
        output valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z,
        input ready
    );
    modport sink (
        input valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z,
        output ready
    );
endinterface

`default_nettype wire

/* src/aabb_axis.sv */
`default_nettype none

module aabb_axis (
    input  wire logic                clk,
    input  wire aabb_pkg::stage_en_t en,
    input  wire aabb_pkg::coord3_t   box_lo,
    input  wire aabb_pkg::coord3_t   box_hi,
    input  wire aabb_pkg::coeff3_t   coeff,
    input  wire aabb_pkg::coord_t    trans,
    output aabb_pkg::coord_t         res_lo,
    output aabb_pkg::coord_t         res_hi
);

    logic signed [aabb_pkg::PROD_BITS-1:0] pa_reg [aabb_pkg::AXES];
    logic signed [aabb_pkg::PROD_BITS-1:0] pb_reg [aabb_pkg::AXES];
    logic signed [aabb_pkg::PROD_BITS-1:0] pa_next [aabb_pkg::AXES];
    logic signed [aabb_pkg::PROD_BITS-1:0] pb_next [aabb_pkg::AXES];
    logic signed [aabb_pkg::SUM_BITS-1:0]  sum_lo;
    logic signed [aabb_pkg::SUM_BITS-1:0]  sum_hi;
    aabb_pkg::coord_t                      res_lo_reg;
    aabb_pkg::coord_t                      res_hi_reg;

    // exact product, floor by dropping the fraction bits
    always_comb
    begin
        logic signed [aabb_pkg::FULL_PROD_BITS-1:0] full_a;
        logic signed [aabb_pkg::FULL_PROD_BITS-1:0] full_b;
        for (int r = 0; r < aabb_pkg::AXES; r++)
        begin
            full_a = aabb_pkg::FULL_PROD_BITS'($signed(box_lo[r]))
                     * aabb_pkg::FULL_PROD_BITS'($signed(coeff[r]));
            full_b = aabb_pkg::FULL_PROD_BITS'($signed(box_hi[r]))
                     * aabb_pkg::FULL_PROD_BITS'($signed(coeff[r]));
            pa_next[r] = full_a[aabb_pkg::FULL_PROD_BITS-1:aabb_pkg::COEFF_FRAC];
            pb_next[r] = full_b[aabb_pkg::FULL_PROD_BITS-1:aabb_pkg::COEFF_FRAC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            for (int r = 0; r < aabb_pkg::AXES; r++)
            begin
                pa_reg[r] <= pa_next[r];
                pb_reg[r] <= pb_next[r];
            end
        end
    end

    // sort each pair, smaller to the minimum
    always_comb
    begin
        sum_lo = aabb_pkg::SUM_BITS'($signed(trans));
        sum_hi = aabb_pkg::SUM_BITS'($signed(trans));
        for (int r = 0; r < aabb_pkg::AXES; r++)
        begin
            if (pb_reg[r] <= pa_reg[r])
            begin
                sum_lo = sum_lo + aabb_pkg::SUM_BITS'(pb_reg[r]);
                sum_hi = sum_hi + aabb_pkg::SUM_BITS'(pa_reg[r]);
            end
            else
            begin
                sum_lo = sum_lo + aabb_pkg::SUM_BITS'(pa_reg[r]);
                sum_hi = sum_hi + aabb_pkg::SUM_BITS'(pb_reg[r]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.res)
        begin
            res_lo_reg <= aabb_pkg::sat_coord(sum_lo);
            res_hi_reg <= aabb_pkg::sat_coord(sum_hi);
        end
    end

    assign res_lo = res_lo_reg;
    assign res_hi = res_hi_reg;

endmodule

`default_nettype wire

/* src/aabb_affine_transform.sv */
// channel   | dir | handshake        | payload
// ----------+-----+------------------+---------------------------------------------
// box_in    | in  | valid / ready    | in_lo_x..in_hi_z, six signed Q16.16 coords
// box_out   | out | valid / ready    | out_lo_x..out_hi_z, six saturated Q16.16 coords
// cfg       | in  | cfg_we (no ack)  | cfg_idx, cfg_data (48 bits)
//
// one item per cycle sustained while box_out.ready is high; a stalled output holds the flow
// stages: input register, product register (18 multiplies), result register
// each stage refills as it drains, so a stalled output still lets earlier stages fill
// reset returns identity coefficients and zero translation, and empties the pipeline
`default_nettype none

module aabb_affine_transform (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    aabb_in_if.sink                                      box_in,
    aabb_out_if.source                                   box_out,
    input  wire logic                                    cfg_we,
    input  wire logic [aabb_pkg::CFG_IDX_BITS-1:0]       cfg_idx,
    input  wire logic [aabb_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    aabb_pkg::coeff_row_t coeff_reg [aabb_pkg::AXES];
    aabb_pkg::coord_t     trans_reg [aabb_pkg::AXES];

    aabb_pkg::coord3_t    box_lo_reg;
    aabb_pkg::coord3_t    box_hi_reg;

    logic                 a_valid_reg;
    logic                 b_valid_reg;
    logic                 c_valid_reg;
    logic                 a_valid_next;
    logic                 b_valid_next;
    logic                 c_valid_next;
    logic                 a_ready;
    logic                 b_ready;
    logic                 c_ready;
    logic                 load_a;
    aabb_pkg::stage_en_t  en;

    aabb_pkg::coord3_t    res_lo;
    aabb_pkg::coord3_t    res_hi;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < aabb_pkg::AXES; k++)
            begin
                coeff_reg[k] <= aabb_pkg::COEFF_REG_BITS'(aabb_pkg::COEFF_ONE)
                                << (k * aabb_pkg::COEFF_BITS);
                trans_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                aabb_pkg::REG_FROM_X_COEFFS: coeff_reg[0] <= cfg_data;
                aabb_pkg::REG_FROM_Y_COEFFS: coeff_reg[1] <= cfg_data;
                aabb_pkg::REG_FROM_Z_COEFFS: coeff_reg[2] <= cfg_data;
                aabb_pkg::REG_TRANS_X:       trans_reg[0] <= cfg_data[aabb_pkg::COORD_BITS-1:0];
                aabb_pkg::REG_TRANS_Y:       trans_reg[1] <= cfg_data[aabb_pkg::COORD_BITS-1:0];
                aabb_pkg::REG_TRANS_Z:       trans_reg[2] <= cfg_data[aabb_pkg::COORD_BITS-1:0];
                default:                     ;
            endcase
        end
    end

    // pipeline control
    always_comb
    begin
        c_ready = !c_valid_reg || box_out.ready;
        b_ready = !b_valid_reg || c_ready;
        a_ready = !a_valid_reg || b_ready;
        load_a  = box_in.valid && a_ready;
        en.prod = a_valid_reg && b_ready;
        en.res  = b_valid_reg && c_ready;

        a_valid_next = load_a  ? 1'b1 : (b_ready ? 1'b0 : a_valid_reg);
        b_valid_next = en.prod ? 1'b1 : (c_ready ? 1'b0 : b_valid_reg);
        c_valid_next = en.res  ? 1'b1 : (box_out.ready ? 1'b0 : c_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            box_lo_reg <= {box_in.in_lo_z, box_in.in_lo_y, box_in.in_lo_x};
            box_hi_reg <= {box_in.in_hi_z, box_in.in_hi_y, box_in.in_hi_x};
        end
    end

    for (genvar k = 0; k < aabb_pkg::AXES; k++)
    begin : g_axis
        aabb_pkg::coeff3_t coeff;

        for (genvar r = 0; r < aabb_pkg::AXES; r++)
        begin : g_coeff
            assign coeff[r] = coeff_reg[r][k*aabb_pkg::COEFF_BITS +: aabb_pkg::COEFF_BITS];
        end

        aabb_axis u_axis (
            .clk    (clk),
            .en     (en),
            .box_lo (box_lo_reg),
            .box_hi (box_hi_reg),
            .coeff  (coeff),
            .trans  (trans_reg[k]),
            .res_lo (res_lo[k]),
            .res_hi (res_hi[k])
        );
    end

    assign box_in.ready     = a_ready;
    assign box_out.valid    = c_valid_reg;
    assign box_out.out_lo_x = res_lo[0];
    assign box_out.out_lo_y = res_lo[1];
    assign box_out.out_lo_z = res_lo[2];
    assign box_out.out_hi_x = res_hi[0];
    assign box_out.out_hi_y = res_hi[1];
    assign box_out.out_hi_z = res_hi[2];

endmodule

`default_nettype wire

/* src/aabb_checker.sv */
`default_nettype none

module aabb_checker (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    input  wire logic                                   in_ready,
    input  wire logic                                   out_valid,
    input  wire logic                                   out_ready,
    input  wire logic [6*aabb_pkg::COORD_BITS-1:0]      out_payload
);

    // items accepted and not yet delivered
    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg + 3'(in_acc) - 3'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_payload))
        else $error("result item changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 3'd0))
        else $error("result item without a pending input item");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("more items in flight than pipeline stages");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && out_ready) ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("item not delivered within three cycles on a free output");

endmodule

bind aabb_affine_transform aabb_checker u_aabb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (box_in.valid),
    .in_ready    (box_in.ready),
    .out_valid   (box_out.valid),
    .out_ready   (box_out.ready),
    .out_payload ({box_out.out_lo_x, box_out.out_lo_y, box_out.out_lo_z,
                   box_out.out_hi_x, box_out.out_hi_y, box_out.out_hi_z})
);

`default_nettype wire
